FILE: hw/rtl/ttfs_pkg.sv
// Package for the two-table flow sketch insert block.
// Types and constants shared with two_table_flow_sketch_insert; no dependencies.
package ttfs_pkg;

  typedef enum logic [1:0] {
    OUT_CLAIMED  = 2'd0,
    OUT_MATCHED  = 2'd1,
    OUT_REPLACED = 2'd2,
    OUT_KEPT     = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_FIN,
    ST_READ,
    ST_DECIDE,
    ST_PROD,
    ST_OUT,
    ST_CLEAR
  } state_e;

  localparam logic [31:0] C1      = 32'hcc9e2d51;
  localparam logic [31:0] C2      = 32'h1b873593;
  localparam logic [31:0] FMIX1   = 32'h85ebca6b;
  localparam logic [31:0] FMIX2   = 32'hc2b2ae35;
  localparam logic [31:0] HADD    = 32'he6546b64;
  localparam logic [31:0] CNT_MAX = 32'hffffffff;

endpackage

FILE: hw/rtl/two_table_flow_sketch_insert.sv
// Two-table flow sketch insert: hashes a key into two bucket tables and updates one.
// Depends on ttfs_pkg.
//
//  channel | signals                                        | dir
//  request | req_valid_i/req_ready_o, flow_key_i, random_draw_i | in
//  result  | res_valid_o/res_ready_i, table_used_o, bucket_index_o, count_after_o, outcome_o | out
//
// After a request is taken, the steps to its result are: the two hashes (five mix steps
// and a finish step each, one shared 32x32 multiply per cycle), memory read, decide, a
// 32x32 product for the replace test when it runs, write and result. The block returns
// to idle before the next request; a bucket count that is not a power of two adds a
// reciprocal reduction to each hash's finish step.
// After reset a clearing pass writes every bucket of both tables.
// A request is taken while a result waits; it stalls at write-back until that result is taken.
module two_table_flow_sketch_insert #(
  parameter int BUCKETS_PER_TABLE = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [31:0] flow_key_i,
  input  logic [31:0] random_draw_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        table_used_o,
  output logic [9:0]  bucket_index_o,
  output logic [31:0] count_after_o,
  output logic [1:0]  outcome_o
);

  localparam int AW = (BUCKETS_PER_TABLE > 1) ? $clog2(BUCKETS_PER_TABLE) : 1;
  localparam int IW = (AW > 10) ? AW : 10;
  localparam logic [AW:0] LAST = (AW+1)'(BUCKETS_PER_TABLE - 1);
  localparam bit POW2 = ((BUCKETS_PER_TABLE & (BUCKETS_PER_TABLE - 1)) == 0);
  localparam logic [31:0] NB = 32'(BUCKETS_PER_TABLE);
  localparam logic [63:0] NB64 = 64'(BUCKETS_PER_TABLE);
  // floor(2^(31+AW) / buckets); quotient estimate is exact or one low
  localparam logic [63:0] RECIP_W = (64'd1 << (31 + AW)) / NB64;
  localparam logic [31:0] RECIP = RECIP_W[31:0];

  logic [63:0] mem0 [BUCKETS_PER_TABLE];
  logic [63:0] mem1 [BUCKETS_PER_TABLE];
  logic [63:0] rd0_q, rd1_q;

  ttfs_pkg::state_e st_q, st_d;
  logic [3:0]  step_q, step_d;
  logic [31:0] key_q, draw_q, h_q, h_d, k_q, k_d;
  logic        seed_q, seed_d;
  logic [AW-1:0] idx0_q, idx0_d, idx1_q, idx1_d, clr_q, clr_d;
  logic        used_q, used_d;
  logic [31:0] cnt_q, cnt_d;
  logic [1:0]  oc_q, oc_d;
  logic [63:0] prod_q;
  logic [31:0] prod_a, prod_b;
  logic        res_v_q, res_v_d;
  logic        res_tbl_q, res_tbl_d;
  logic [9:0]  res_idx_q, res_idx_d;
  logic [31:0] res_cnt_q, res_cnt_d;
  logic [1:0]  res_oc_q, res_oc_d;
  logic        we0, we1;
  logic [AW-1:0] wa;
  logic [63:0] wd;
  logic        fin_done;
  logic [AW-1:0] fin_idx;
  logic [63:0] qn;
  logic        repl;

  logic [31:0] mul_a, mul_b, mul_p;
  assign mul_p = mul_a * mul_b;

  logic [31:0] c0, c1, k0, k1, cinc;
  assign k0 = rd0_q[63:32];
  assign c0 = rd0_q[31:0];
  assign k1 = rd1_q[63:32];
  assign c1 = rd1_q[31:0];

  logic [IW-1:0] bidx;
  assign bidx = IW'(used_q ? idx1_q : idx0_q);
  assign repl = (oc_q == ttfs_pkg::OUT_KEPT) && (prod_q[63:32] == 32'd0);

  always_comb begin
    st_d = st_q; step_d = step_q; h_d = h_q; k_d = k_q; seed_d = seed_q;
    idx0_d = idx0_q; idx1_d = idx1_q; clr_d = clr_q; used_d = used_q;
    cnt_d = cnt_q; oc_d = oc_q; res_v_d = res_v_q;
    res_tbl_d = res_tbl_q; res_idx_d = res_idx_q; res_cnt_d = res_cnt_q; res_oc_d = res_oc_q;
    we0 = 1'b0; we1 = 1'b0; wa = clr_q; wd = '0;
    mul_a = k_q; mul_b = ttfs_pkg::C1; cinc = 32'd0;
    prod_a = draw_q; prod_b = cnt_q;
    fin_done = 1'b0; fin_idx = h_q[AW-1:0]; qn = '0;
    if (res_v_q && res_ready_i) res_v_d = 1'b0;
    case (st_q)
      ttfs_pkg::ST_CLEAR: begin
        we0 = 1'b1; we1 = 1'b1;
        clr_d = clr_q + 1'b1;
        if ({1'b0, clr_q} == LAST) st_d = ttfs_pkg::ST_IDLE;
      end
      ttfs_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          k_d = flow_key_i; h_d = 32'd0; seed_d = 1'b0; step_d = 4'd0;
          st_d = ttfs_pkg::ST_MIX;
        end
      end
      ttfs_pkg::ST_MIX: begin
        step_d = step_q + 4'd1;
        case (step_q)
          4'd0: begin mul_a = k_q; mul_b = ttfs_pkg::C1; k_d = mul_p; end
          4'd1: begin mul_a = {k_q[16:0], k_q[31:17]}; mul_b = ttfs_pkg::C2; k_d = mul_p; end
          4'd2: begin
            h_d = {32'(seed_q)} ^ k_q;
            h_d = {h_d[18:0], h_d[31:19]};
            h_d = (h_d * 32'd5 + ttfs_pkg::HADD) ^ 32'd4;
            h_d = h_d ^ (h_d >> 16);
          end
          4'd3: begin mul_a = h_q; mul_b = ttfs_pkg::FMIX1; h_d = mul_p ^ (mul_p >> 13); end
          default: begin
            mul_a = h_q; mul_b = ttfs_pkg::FMIX2;
            h_d = mul_p ^ (mul_p >> 16);
            st_d = ttfs_pkg::ST_FIN;
          end
        endcase
      end
      ttfs_pkg::ST_FIN: begin
        step_d = step_q + 4'd1;
        if (POW2) begin
          fin_done = 1'b1;
        end else begin
          case (step_q)
            4'd5: begin prod_a = h_q; prod_b = RECIP; end
            4'd6: begin
              qn = (prod_q >> (31 + AW)) * NB64;
              h_d = h_q - qn[31:0];
            end
            default: begin
              fin_idx = (h_q >= NB) ? AW'(h_q - NB) : h_q[AW-1:0];
              fin_done = 1'b1;
            end
          endcase
        end
        if (fin_done) begin
          if (!seed_q) begin
            idx0_d = fin_idx; seed_d = 1'b1; k_d = key_q; step_d = 4'd0;
            st_d = ttfs_pkg::ST_MIX;
          end else begin
            idx1_d = fin_idx; st_d = ttfs_pkg::ST_READ;
          end
        end
      end
      ttfs_pkg::ST_READ: st_d = ttfs_pkg::ST_DECIDE;
      ttfs_pkg::ST_DECIDE: begin
        st_d = ttfs_pkg::ST_OUT;
        if (c0 == 32'd0) begin
          used_d = 1'b0; cnt_d = 32'd1; oc_d = ttfs_pkg::OUT_CLAIMED;
        end else if (k0 == key_q) begin
          used_d = 1'b0; cnt_d = (c0 == ttfs_pkg::CNT_MAX) ? c0 : c0 + 32'd1;
          oc_d = ttfs_pkg::OUT_MATCHED;
        end else if (c1 == 32'd0) begin
          used_d = 1'b1; cnt_d = 32'd1; oc_d = ttfs_pkg::OUT_CLAIMED;
        end else if (k1 == key_q) begin
          used_d = 1'b1; cnt_d = (c1 == ttfs_pkg::CNT_MAX) ? c1 : c1 + 32'd1;
          oc_d = ttfs_pkg::OUT_MATCHED;
        end else begin
          used_d = (c0 <= c1) ? 1'b0 : 1'b1;
          cinc = (c0 <= c1) ? c0 : c1;
          cnt_d = (cinc == ttfs_pkg::CNT_MAX) ? cinc : cinc + 32'd1;
          oc_d = ttfs_pkg::OUT_KEPT;
          st_d = ttfs_pkg::ST_PROD;
        end
      end
      ttfs_pkg::ST_PROD: st_d = ttfs_pkg::ST_OUT;
      ttfs_pkg::ST_OUT: begin
        wa = used_q ? idx1_q : idx0_q;
        if (oc_q == ttfs_pkg::OUT_KEPT && !repl) begin
          wd = {(used_q ? k1 : k0), cnt_q};
        end else begin
          wd = {key_q, cnt_q};
        end
        if (!res_v_q || res_ready_i) begin
          we0 = !used_q; we1 = used_q;
          res_v_d = 1'b1;
          res_tbl_d = used_q;
          res_idx_d = bidx[9:0];
          res_cnt_d = cnt_q;
          res_oc_d = repl ? ttfs_pkg::OUT_REPLACED : oc_q;
          st_d = ttfs_pkg::ST_IDLE;
        end
      end
      default: st_d = ttfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ttfs_pkg::ST_CLEAR;
      clr_q <= '0;
      res_v_q <= 1'b0;
      step_q <= '0;
      seed_q <= 1'b0;
    end else begin
      st_q <= st_d;
      clr_q <= clr_d;
      res_v_q <= res_v_d;
      step_q <= step_d;
      seed_q <= seed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d; k_q <= k_d; idx0_q <= idx0_d; idx1_q <= idx1_d;
    used_q <= used_d; cnt_q <= cnt_d; oc_q <= oc_d;
    res_tbl_q <= res_tbl_d; res_idx_q <= res_idx_d;
    res_cnt_q <= res_cnt_d; res_oc_q <= res_oc_d;
    prod_q <= 64'(prod_a) * 64'(prod_b);
    if (st_q == ttfs_pkg::ST_IDLE && st_d == ttfs_pkg::ST_MIX) begin
      key_q <= flow_key_i; draw_q <= random_draw_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0) mem0[wa] <= wd;
    if (we1) mem1[wa] <= wd;
    rd0_q <= mem0[idx0_q];
    rd1_q <= mem1[idx1_q];
  end

  assign req_ready_o    = (st_q == ttfs_pkg::ST_IDLE);
  assign res_valid_o    = res_v_q;
  assign table_used_o   = res_tbl_q;
  assign bucket_index_o = res_idx_q;
  assign count_after_o  = res_cnt_q;
  assign outcome_o      = res_oc_q;

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ttfs_pkg::ST_IDLE) |-> !req_ready_o) else $error("ready while busy");
  a_res_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> $past(st_q) == ttfs_pkg::ST_OUT) else $error("stray result");
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> count_after_o != 32'd0) else $error("zero count");

endmodule

FILE: verif/tb_top.sv
// Testbench for two_table_flow_sketch_insert: directed table, then random requests.
// Results are checked against a behavioral model of the two hash tables. Uses ttfs_pkg.
`timescale 1ns / 100ps

module tb_top;

  localparam int NBUCKETS = 1024;
  localparam int NRANDOM = 2000;
  localparam int MAX_CYCLES = 1000000;

  typedef struct packed {
    logic       tbl;
    logic [9:0] idx;
    logic [31:0] cnt;
    ttfs_pkg::outcome_e outc;
  } sketch_res_t;

  typedef struct {
    logic [31:0] key;
    logic [31:0] draw;
    bit          typed;
    ttfs_pkg::outcome_e outc;
    logic [31:0] cnt;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid_i = 1'b0;
  logic        req_ready_o;
  logic [31:0] flow_key_i = '0;
  logic [31:0] random_draw_i = '0;
  logic        res_valid_o;
  logic        res_ready_i = 1'b0;
  logic        table_used_o;
  logic [9:0]  bucket_index_o;
  logic [31:0] count_after_o;
  logic [1:0]  outcome_o;

  logic [31:0] key_mem [2][NBUCKETS];
  logic [31:0] cnt_mem [2][NBUCKETS];
  sketch_res_t expected_q[$];
  logic [31:0] known_keys[$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 0;

  two_table_flow_sketch_insert dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic logic [31:0] rotl(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] murmur_word(logic [31:0] key, logic [31:0] seed);
    logic [31:0] k;
    logic [31:0] h;
    k = key * ttfs_pkg::C1;
    k = rotl(k, 15);
    k = k * ttfs_pkg::C2;
    h = seed ^ k;
    h = rotl(h, 13);
    h = h * 32'd5 + ttfs_pkg::HADD;
    h = h ^ 32'd4;
    h = h ^ (h >> 16);
    h = h * ttfs_pkg::FMIX1;
    h = h ^ (h >> 13);
    h = h * ttfs_pkg::FMIX2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == ttfs_pkg::CNT_MAX) ? c : c + 32'd1;
  endfunction

  function automatic sketch_res_t insert_flow(logic [31:0] key, logic [31:0] draw);
    sketch_res_t r;
    int          b [2];
    bit          done;
    int          t;
    logic [63:0] prod;
    done = 0;
    r.outc = ttfs_pkg::OUT_KEPT;
    r.tbl = 1'b0;
    for (t = 0; t < 2; t++) b[t] = murmur_word(key, t) % NBUCKETS;
    for (t = 0; t < 2 && !done; t++) begin
      if (cnt_mem[t][b[t]] == 0) begin
        key_mem[t][b[t]] = key;
        cnt_mem[t][b[t]] = 32'd1;
        r.tbl = t[0];
        r.outc = ttfs_pkg::OUT_CLAIMED;
        done = 1;
      end else if (key_mem[t][b[t]] == key) begin
        cnt_mem[t][b[t]] = sat_inc(cnt_mem[t][b[t]]);
        r.tbl = t[0];
        r.outc = ttfs_pkg::OUT_MATCHED;
        done = 1;
      end
    end
    if (!done) begin
      r.tbl = (cnt_mem[0][b[0]] <= cnt_mem[1][b[1]]) ? 1'b0 : 1'b1;
      cnt_mem[r.tbl][b[r.tbl]] = sat_inc(cnt_mem[r.tbl][b[r.tbl]]);
      prod = {32'd0, draw} * {32'd0, cnt_mem[r.tbl][b[r.tbl]]};
      if (prod < 64'h1_0000_0000) begin
        key_mem[r.tbl][b[r.tbl]] = key;
        r.outc = ttfs_pkg::OUT_REPLACED;
      end
    end
    r.idx = b[r.tbl][9:0];
    r.cnt = cnt_mem[r.tbl][b[r.tbl]];
    return r;
  endfunction

  // one request; valid is lowered only when an idle gap follows
  task automatic send_request(logic [31:0] key, logic [31:0] draw, bit typed,
                              ttfs_pkg::outcome_e outc, logic [31:0] cnt);
    sketch_res_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid_i <= 1'b1;
    flow_key_i <= key;
    random_draw_i <= draw;
    do @(posedge clk_i); while (!req_ready_o);
    r = insert_flow(key, draw);
    if (typed) begin
      r.outc = outc;
      r.cnt = cnt;
    end
    expected_q.push_back(r);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold == 0) hold = 300;
      if (hold > 0) begin
        hold--;
        if (hold == 0) hold_req = 0;
        res_ready_i <= 1'b0;
      end else begin
        res_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    sketch_res_t e;
    if (rst_ni && res_valid_o && res_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (table_used_o !== e.tbl) begin
          $error("table_used exp %0d got %0d", e.tbl, table_used_o);
          errors++;
        end
        if (bucket_index_o !== e.idx) begin
          $error("bucket_index exp %0d got %0d", e.idx, bucket_index_o);
          errors++;
        end
        if (count_after_o !== e.cnt) begin
          $error("count_after exp %0d got %0d", e.cnt, count_after_o);
          errors++;
        end
        if (outcome_o !== e.outc) begin
          $error("outcome exp %0d got %0d", e.outc, outcome_o);
          errors++;
        end
      end
    end
  end

  stim_row_t rows [] = '{
    '{32'h0000_0000, 32'h0000_0000, 1, ttfs_pkg::OUT_CLAIMED, 32'd1},
    '{32'h0000_0000, 32'hffff_ffff, 1, ttfs_pkg::OUT_MATCHED, 32'd2},
    '{32'h0000_0000, 32'h8000_0000, 1, ttfs_pkg::OUT_MATCHED, 32'd3},
    '{32'hffff_ffff, 32'h0000_0000, 1, ttfs_pkg::OUT_CLAIMED, 32'd1},
    '{32'hffff_ffff, 32'hffff_ffff, 1, ttfs_pkg::OUT_MATCHED, 32'd2},
    '{32'h8000_0000, 32'h7fff_ffff, 1, ttfs_pkg::OUT_CLAIMED, 32'd1},
    '{32'h0000_0001, 32'h0000_0001, 1, ttfs_pkg::OUT_CLAIMED, 32'd1},
    '{32'h5555_5555, 32'haaaa_aaaa, 0, ttfs_pkg::OUT_KEPT, 32'd0},
    '{32'haaaa_aaaa, 32'h5555_5555, 0, ttfs_pkg::OUT_KEPT, 32'd0},
    '{32'h7fff_ffff, 32'h0000_0000, 0, ttfs_pkg::OUT_KEPT, 32'd0},
    '{32'h0000_0001, 32'hffff_ffff, 1, ttfs_pkg::OUT_MATCHED, 32'd2},
    '{32'h1234_5678, 32'h8000_0001, 0, ttfs_pkg::OUT_KEPT, 32'd0}
  };

  initial begin
    logic [31:0] key;
    logic [31:0] draw;
    int          ph;
    int          i;
    int          wait_cnt;
    for (ph = 0; ph < 2; ph++)
      for (i = 0; i < NBUCKETS; i++) begin
        key_mem[ph][i] = '0;
        cnt_mem[ph][i] = '0;
      end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[j])
      send_request(rows[j].key, rows[j].draw, rows[j].typed, rows[j].outc, rows[j].cnt);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (i = 0; i < NRANDOM / 4; i++) begin
        if (ph == 0 && i == 100) hold_req = 1;
        if (known_keys.size() > 0 && $urandom_range(99) < 40) begin
          key = known_keys[$urandom_range(known_keys.size() - 1)];
        end else begin
          key = $urandom;
          known_keys.push_back(key);
        end
        case ($urandom_range(9))
          0: draw = 32'hffff_ffff;
          1: draw = $urandom_range(255);
          2: draw = $urandom >> $urandom_range(31);
          default: draw = $urandom;
        endcase
        send_request(key, draw, 0, ttfs_pkg::OUT_KEPT, 32'd0);
      end
    end
    req_valid_i <= 1'b0;
    recv_stall_pct = 0;

    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (40) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: two_table_flow_sketch_insert.f
hw/rtl/ttfs_pkg.sv
hw/rtl/two_table_flow_sketch_insert.sv
verif/tb_top.sv
